FILE: src/lmsd_pkg.sv
// Package with shared widths, register indexes and the pin sequence phases of the LED matrix scan driver.
package lmsd_pkg;

  localparam int DEFAULT_PANEL_WIDTH = 64;
  localparam int DEFAULT_SCAN_ROWS   = 16;

  localparam int COLOR_W   = 3;
  localparam int COLORS_W  = 4 * COLOR_W;
  localparam int ROW_PIN_W = 4;
  localparam int FRAME_W   = 32;
  localparam int ROWS_CFG_W = 5;
  localparam int COLS_CFG_W = 7;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 7;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 56;

  localparam logic [CFG_INDEX_W-1:0] REG_ROWS_IN_USE    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COLUMNS_IN_USE = 2'd1;

  typedef enum logic [2:0] {
    PH_SELECT,
    PH_DATA,
    PH_CLK_HIGH,
    PH_CLK_LOW,
    PH_BLANK,
    PH_LATCH_HIGH,
    PH_LATCH_LOW
  } phase_t;

endpackage

FILE: src/led_matrix_scan_driver.sv
// Top level of the LED matrix scan driver: pixel stream in, panel pin states out.
//
// Each accepted pixel transaction yields one output transaction per panel pin state: an
// optional row select at the first column of a row, then data, clock high and clock low,
// and at the end of a row blank, latch high and latch low, so 3, 4, 6 or 7 output
// transactions per pixel. One output transaction leaves per cycle unless a low out_tready
// holds the output register, and the next pixel is accepted in the cycle in which the final
// pin state of the current one enters the output register, so pixels never overlap.
// Configuration writes take effect for the next pixel and are always ready.
module led_matrix_scan_driver
  import lmsd_pkg::*;
#(
  parameter int PANEL_WIDTH = DEFAULT_PANEL_WIDTH,
  parameter int SCAN_ROWS   = DEFAULT_SCAN_ROWS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // upper_rgb_first[2:0], lower_rgb_first[5:3], upper_rgb_second[8:6],
  // lower_rgb_second[11:9], zero[15:12]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // pin_upper_first[2:0], pin_lower_first[5:3], pin_upper_second[8:6],
  // pin_lower_second[11:9], row_address[15:12], shift_clock[16], latch_pulse[17],
  // blank[18], frames_shown[50:19], zero[55:51]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int CW  = $clog2(PANEL_WIDTH + 1);
  localparam int RW  = $clog2(SCAN_ROWS + 1);
  localparam int CLW = 9;
  localparam int RLW = 6;

  logic [ROWS_CFG_W-1:0] rows_in_use_r;
  logic [COLS_CFG_W-1:0] columns_in_use_r;
  logic [CW-1:0]         column_index_r;
  logic [RW-1:0]         row_index_r;
  logic [FRAME_W-1:0]    frame_counter_r;
  logic [COLORS_W-1:0]   last_colors_r;

  logic                  work_valid_r;
  phase_t                phase_r;
  phase_t                phase_nxt;
  logic [COLORS_W-1:0]   w_colors_r;
  logic [COLORS_W-1:0]   w_prev_r;
  logic [ROW_PIN_W-1:0]  w_row_r;
  logic [FRAME_W-1:0]    w_frames_r;
  logic                  w_end_r;

  logic                  out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic                  out_last_r;

  logic [CLW-1:0] col_limit;
  logic [RLW-1:0] row_limit;
  logic [CW:0]    column_inc;
  logic [RW:0]    row_inc;
  logic           row_end;
  logic           frame_end;
  logic           accept;
  logic           emit;
  logic           is_last;

  logic [COLORS_W-1:0]  r_colors;
  logic                 r_clock;
  logic                 r_latch;
  logic                 r_blank;

  always_comb begin
    if (columns_in_use_r == '0) begin
      col_limit = CLW'(1);
    end else if ({2'b00, columns_in_use_r} > CLW'(PANEL_WIDTH)) begin
      col_limit = CLW'(PANEL_WIDTH);
    end else begin
      col_limit = {2'b00, columns_in_use_r};
    end
    if (rows_in_use_r == '0) begin
      row_limit = RLW'(1);
    end else if ({1'b0, rows_in_use_r} > RLW'(SCAN_ROWS)) begin
      row_limit = RLW'(SCAN_ROWS);
    end else begin
      row_limit = {1'b0, rows_in_use_r};
    end
  end

  assign column_inc = {1'b0, column_index_r} + (CW + 1)'(1);
  assign row_inc    = {1'b0, row_index_r} + (RW + 1)'(1);
  assign row_end    = CLW'(column_inc) >= col_limit;
  assign frame_end  = RLW'(row_inc) >= row_limit;

  assign is_last  = (phase_r == PH_LATCH_LOW) || ((phase_r == PH_CLK_LOW) && !w_end_r);
  assign emit     = work_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !work_valid_r || (emit && is_last);
  assign accept   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_comb begin
    case (phase_r)
      PH_SELECT:     phase_nxt = PH_DATA;
      PH_DATA:       phase_nxt = PH_CLK_HIGH;
      PH_CLK_HIGH:   phase_nxt = PH_CLK_LOW;
      PH_CLK_LOW:    phase_nxt = PH_BLANK;
      PH_BLANK:      phase_nxt = PH_LATCH_HIGH;
      PH_LATCH_HIGH: phase_nxt = PH_LATCH_LOW;
      default:       phase_nxt = PH_LATCH_LOW;
    endcase
  end

  always_comb begin
    r_colors = w_colors_r;
    r_clock  = 1'b0;
    r_latch  = 1'b0;
    r_blank  = 1'b0;
    case (phase_r)
      PH_SELECT: begin
        r_colors = w_prev_r;
      end
      PH_DATA: begin
      end
      PH_CLK_HIGH: begin
        r_clock = 1'b1;
      end
      PH_CLK_LOW: begin
      end
      PH_BLANK: begin
        r_blank = 1'b1;
      end
      PH_LATCH_HIGH: begin
        r_blank = 1'b1;
        r_latch = 1'b1;
      end
      default: begin
        r_blank = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_in_use_r    <= ROWS_CFG_W'(DEFAULT_SCAN_ROWS);
      columns_in_use_r <= COLS_CFG_W'(DEFAULT_PANEL_WIDTH);
      column_index_r   <= '0;
      row_index_r      <= '0;
      frame_counter_r  <= '0;
      last_colors_r    <= '0;
      work_valid_r     <= 1'b0;
      phase_r          <= PH_DATA;
      out_valid_r      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_ROWS_IN_USE) begin
          rows_in_use_r <= cfg_data[ROWS_CFG_W-1:0];
        end else if (cfg_index == REG_COLUMNS_IN_USE) begin
          columns_in_use_r <= cfg_data;
        end
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (accept) begin
        work_valid_r  <= 1'b1;
        phase_r       <= (column_index_r == '0) ? PH_SELECT : PH_DATA;
        last_colors_r <= in_tdata[COLORS_W-1:0];
        if (row_end) begin
          column_index_r <= '0;
          if (frame_end) begin
            row_index_r     <= '0;
            frame_counter_r <= frame_counter_r + FRAME_W'(1);
          end else begin
            row_index_r <= row_inc[RW-1:0];
          end
        end else begin
          column_index_r <= column_inc[CW-1:0];
        end
      end else if (emit) begin
        if (is_last) begin
          work_valid_r <= 1'b0;
        end else begin
          phase_r <= phase_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      w_colors_r <= in_tdata[COLORS_W-1:0];
      w_prev_r   <= last_colors_r;
      w_row_r    <= ROW_PIN_W'(row_index_r);
      w_frames_r <= frame_counter_r;
      w_end_r    <= row_end;
    end
    if (emit) begin
      out_data_r <= {5'b00000, w_frames_r, r_blank, r_latch, r_clock, w_row_r, r_colors};
      out_last_r <= is_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule
